>>> rtl/fifo_slot_allocator_defines.svh
// Assertion helpers shared by the allocator RTL.
`ifndef FIFO_SLOT_ALLOCATOR_DEFINES_SVH
`define FIFO_SLOT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/fsa_pkg.sv
`timescale 1ns / 1ps

package fsa_pkg;

    // Field and register widths.
    localparam int ADDR_W     = 48;
    localparam int SIZE_W     = 13;
    localparam int COUNT_W    = 11;
    localparam int IDX_W      = 10;
    localparam int STAT_W     = 3;
    localparam int FUNC_W     = 2;
    localparam int RUN_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Register values after reset.
    localparam int SLOT_SIZE_RST  = 32;
    localparam int SLOT_COUNT_RST = 1024;

    // Divider: quotient bits resolved per cycle.
    localparam int DIV_BITS   = 4;
    localparam int DIV_CYCLES = ADDR_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REFILL = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_ENOUGH = 3'd1;
    localparam logic [STAT_W-1:0] STAT_MISALIGNED = 3'd2;
    localparam logic [STAT_W-1:0] STAT_RANGE      = 3'd3;
    localparam logic [STAT_W-1:0] STAT_RING_FULL  = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_BASE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GPU_BASE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_SIZE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GPU_VISIBLE = 3'd4;

    // Divider status and quotient as seen by the control logic.
    typedef struct packed {
        logic              done;
        logic              exact;
        logic [ADDR_W-1:0] quot;
    } t_div_res;

endpackage

>>> rtl/fsa_divider.sv
`timescale 1ns / 1ps

module fsa_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [fsa_pkg::ADDR_W-1:0]  i_num,
    input  logic [fsa_pkg::SIZE_W-1:0]  i_den,
    output fsa_pkg::t_div_res           o_res
);
    import fsa_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [ADDR_W-1:0]    r_num;
    logic [SIZE_W-1:0]    r_rem;
    logic [SIZE_W-1:0]    r_den;
    logic [ADDR_W-1:0]    n_num;
    logic [SIZE_W-1:0]    n_rem;
    logic [SIZE_W:0]      trial;

    // Restoring division, DIV_BITS quotient bits per cycle. The dividend
    // shifts out at the top while quotient bits shift in at the bottom.
    always_comb begin
        n_rem = r_rem;
        n_num = r_num;
        trial = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            trial = {n_rem, n_num[ADDR_W-1]};
            n_num = {n_num[ADDR_W-2:0], 1'b0};
            if (trial >= {1'b0, r_den}) begin
                n_rem    = SIZE_W'(trial - {1'b0, r_den});
                n_num[0] = 1'b1;
            end else begin
                n_rem = trial[SIZE_W-1:0];
            end
        end
    end

    // Step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Dividend, remainder and divisor.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_res.done  = r_done;
    assign o_res.exact = (r_rem == '0);
    assign o_res.quot  = r_num;

endmodule

>>> rtl/fifo_slot_allocator.sv
`timescale 1ns / 1ps
`include "fifo_slot_allocator_defines.svh"

// FIFO free-list allocator for a table of equal-sized slots.
// Configuration: write i_cfg_data to register i_cfg_idx while i_cfg_we is
// high; do so only while the block is idle. Register order: cpu_base,
// gpu_base, slot_size, slot_count, gpu_visible.
// Requests: a transaction is taken at a clock edge with start high and busy
// low; i_func selects allocate, free or refill.
// Results: each result shows for one cycle with o_strobe high. The receiver
// cannot stall, so results are never held back.
// Allocate of n slots: results come one per cycle through the ring read, the
// multiply and the result register; busy stays high until the last index is
// multiplied. The ring memory read and the index multiply set the pipeline depth.
// Free: the address offset is divided by slot_size 4 bits per cycle, and the
// result shows once the divider is done; busy stays high until then.
// A free below the base or with zero slot_size answers on the next cycle.
// Refill keeps busy low and gives no result; an allocate of zero gives none.
// Reset loads the register defaults and a full ring of slot_count indices at
// once: a fill mark stands in for the unwritten entries, so there is no
// clearing pass and a request can be taken right after reset.
module fifo_slot_allocator #(
    parameter int SLOTS   = 1024,
    parameter int MAX_RUN = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fsa_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fsa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            start,
    output logic                            busy,
    input  logic [fsa_pkg::FUNC_W-1:0]      i_func,
    input  logic [fsa_pkg::RUN_W-1:0]       i_run_length,
    input  logic [fsa_pkg::ADDR_W-1:0]      i_freed_address,
    output logic                            o_strobe,
    output logic [fsa_pkg::ADDR_W-1:0]      o_slot_cpu_address,
    output logic [fsa_pkg::ADDR_W-1:0]      o_slot_gpu_address,
    output logic [fsa_pkg::IDX_W-1:0]       o_slot_index,
    output logic [fsa_pkg::STAT_W-1:0]      o_status,
    output logic                            o_last
);
    import fsa_pkg::*;

    localparam int PW        = $clog2(SLOTS);
    localparam int CW        = $clog2(SLOTS + 1);
    localparam int TW        = PW + 1;
    localparam int EW        = (PW > COUNT_W) ? COUNT_W : PW;
    localparam int RW        = $clog2(MAX_RUN + 1);
    localparam int PRODW     = EW + SIZE_W;
    localparam int RST_COUNT = (SLOTS < SLOT_COUNT_RST) ? SLOTS : SLOT_COUNT_RST;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ALLOC = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DIV   = 4'b1000
    } t_state;

    // Configuration registers.
    logic [ADDR_W-1:0]  r_cpu_base;
    logic [ADDR_W-1:0]  r_gpu_base;
    logic [SIZE_W-1:0]  r_slot_size;
    logic [COUNT_W-1:0] r_slot_count;
    logic               r_gpu_vis;

    // Ring control.
    t_state             r_state, n_state;
    logic [PW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_total, n_total;
    logic [CW-1:0]      r_fresh_lo, n_fresh_lo;
    logic [CW-1:0]      r_fresh_hi, n_fresh_hi;
    logic [RW-1:0]      r_remain, n_remain;

    // Ring memory.
    logic [EW-1:0]      r_ring [SLOTS];
    logic [EW-1:0]      r_rd_data;
    logic               rd_en;
    logic               mem_we;
    logic [PW-1:0]      tail;
    logic [TW-1:0]      tail_sum;

    // Allocate pipeline.
    logic               r_s1_valid, r_s1_last, r_s1_fresh;
    logic [PW-1:0]      r_s1_pos;
    logic [EW-1:0]      s1_idx;
    logic               r_s2_valid, r_s2_last;
    logic [EW-1:0]      r_s2_idx;
    logic [PRODW-1:0]   r_s2_prod;
    logic               fresh_hit;

    // Result register.
    logic               r_out_valid, n_out_valid;
    logic [ADDR_W-1:0]  r_out_cpu, n_out_cpu;
    logic [ADDR_W-1:0]  r_out_gpu, n_out_gpu;
    logic [IDX_W-1:0]   r_out_idx, n_out_idx;
    logic [STAT_W-1:0]  r_out_status, n_out_status;
    logic               r_out_last, n_out_last;

    // Request decode and divider.
    logic               accept;
    logic [RW-1:0]      run_n;
    logic [CW-1:0]      eff_count;
    logic               div_start;
    t_div_res           div_res;

    assign busy      = (r_state != ST_IDLE);
    assign accept    = start && !busy;
    assign run_n     = (i_run_length > RUN_W'(MAX_RUN)) ? RW'(MAX_RUN) : RW'(i_run_length);
    assign eff_count = (32'(r_slot_count) > 32'(SLOTS)) ? CW'(SLOTS) : CW'(r_slot_count);

    // Positions from the low fill mark up to the high one still hold their refill value.
    assign fresh_hit = (CW'(r_head) >= r_fresh_lo) && (CW'(r_head) < r_fresh_hi);
    assign s1_idx    = r_s1_fresh ? EW'(r_s1_pos) : r_rd_data;

    // Ring tail for a free, wrapping at the ring depth.
    assign tail_sum = TW'(r_head) + TW'(r_total);
    assign tail     = (tail_sum >= TW'(SLOTS)) ? PW'(tail_sum - TW'(SLOTS)) : PW'(tail_sum);

    fsa_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (i_freed_address - r_cpu_base),
        .i_den   (r_slot_size),
        .o_res   (div_res)
    );

    // Configuration write port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpu_base   <= '0;
            r_gpu_base   <= '0;
            r_slot_size  <= SIZE_W'(SLOT_SIZE_RST);
            r_slot_count <= COUNT_W'(SLOT_COUNT_RST);
            r_gpu_vis    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CPU_BASE:    r_cpu_base   <= i_cfg_data[ADDR_W-1:0];
                CFG_GPU_BASE:    r_gpu_base   <= i_cfg_data[ADDR_W-1:0];
                CFG_SLOT_SIZE:   r_slot_size  <= i_cfg_data[SIZE_W-1:0];
                CFG_SLOT_COUNT:  r_slot_count <= i_cfg_data[COUNT_W-1:0];
                CFG_GPU_VISIBLE: r_gpu_vis    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Main control: request decode, ring pointer updates and result selection.
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_total      = r_total;
        n_fresh_lo   = r_fresh_lo;
        n_fresh_hi   = r_fresh_hi;
        n_remain     = r_remain;
        n_out_valid  = 1'b0;
        n_out_cpu    = r_out_cpu;
        n_out_gpu    = r_out_gpu;
        n_out_idx    = r_out_idx;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        rd_en        = 1'b0;
        mem_we       = 1'b0;
        div_start    = 1'b0;

        // Final allocate stage: base plus offset.
        if (r_s2_valid) begin
            n_out_valid  = 1'b1;
            n_out_cpu    = r_cpu_base + ADDR_W'(r_s2_prod);
            n_out_gpu    = r_gpu_vis ? r_gpu_base + ADDR_W'(r_s2_prod) : '0;
            n_out_idx    = IDX_W'(r_s2_idx);
            n_out_status = STAT_OK;
            n_out_last   = r_s2_last;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_func)
                        FUNC_ALLOC: begin
                            if (run_n != '0) begin
                                if (32'(run_n) > 32'(r_total)) begin
                                    n_out_valid  = 1'b1;
                                    n_out_cpu    = '0;
                                    n_out_gpu    = '0;
                                    n_out_idx    = '0;
                                    n_out_status = STAT_NOT_ENOUGH;
                                    n_out_last   = 1'b1;
                                end else begin
                                    n_remain = run_n;
                                    n_state  = ST_ALLOC;
                                end
                            end
                        end
                        FUNC_FREE: begin
                            if (i_freed_address < r_cpu_base || r_slot_size == '0) begin
                                n_out_valid  = 1'b1;
                                n_out_cpu    = '0;
                                n_out_gpu    = '0;
                                n_out_idx    = '0;
                                n_out_status = (i_freed_address < r_cpu_base) ?
                                               STAT_RANGE : STAT_MISALIGNED;
                                n_out_last   = 1'b1;
                            end else begin
                                div_start = 1'b1;
                                n_state   = ST_DIV;
                            end
                        end
                        FUNC_REFILL: begin
                            n_head     = '0;
                            n_total    = eff_count;
                            n_fresh_lo = '0;
                            n_fresh_hi = eff_count;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ALLOC: begin
                // Pop one index per cycle.
                rd_en    = 1'b1;
                n_head   = (r_head == PW'(SLOTS - 1)) ? '0 : r_head + PW'(1);
                n_total  = r_total - CW'(1);
                n_remain = r_remain - RW'(1);
                if (r_remain == RW'(1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_s2_valid && !r_s1_valid) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (div_res.done) begin
                    n_state      = ST_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_cpu    = '0;
                    n_out_gpu    = '0;
                    n_out_idx    = '0;
                    n_out_last   = 1'b1;
                    if (!div_res.exact) begin
                        n_out_status = STAT_MISALIGNED;
                    end else if (div_res.quot >= ADDR_W'(eff_count)) begin
                        n_out_status = STAT_RANGE;
                    end else if (r_total == CW'(SLOTS)) begin
                        n_out_status = STAT_RING_FULL;
                        n_out_idx    = div_res.quot[IDX_W-1:0];
                    end else begin
                        // Push at the tail; move the fill mark past it.
                        mem_we       = 1'b1;
                        n_total      = r_total + CW'(1);
                        n_out_status = STAT_OK;
                        n_out_idx    = div_res.quot[IDX_W-1:0];
                        if (CW'(tail) >= r_fresh_lo && CW'(tail) < r_fresh_hi) begin
                            n_fresh_lo = CW'(tail) + CW'(1);
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_total     <= CW'(RST_COUNT);
            r_fresh_lo  <= '0;
            r_fresh_hi  <= CW'(RST_COUNT);
            r_remain    <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_total     <= n_total;
            r_fresh_lo  <= n_fresh_lo;
            r_fresh_hi  <= n_fresh_hi;
            r_remain    <= n_remain;
            r_s1_valid  <= rd_en;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Ring memory: one write port for frees, one registered read for allocates.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ring[tail] <= div_res.quot[EW-1:0];
        end
        if (rd_en) begin
            r_rd_data <= r_ring[r_head];
        end
    end

    // Allocate pipeline payload: read, multiply, then add in the result stage.
    always_ff @(posedge i_clk) begin
        r_s1_last    <= (r_remain == RW'(1));
        r_s1_fresh   <= fresh_hit;
        r_s1_pos     <= r_head;
        r_s2_last    <= r_s1_last;
        r_s2_idx     <= s1_idx;
        r_s2_prod    <= PRODW'(s1_idx) * PRODW'(r_slot_size);
        r_out_cpu    <= n_out_cpu;
        r_out_gpu    <= n_out_gpu;
        r_out_idx    <= n_out_idx;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign o_strobe           = r_out_valid;
    assign o_slot_cpu_address = r_out_cpu;
    assign o_slot_gpu_address = r_out_gpu;
    assign o_slot_index       = r_out_idx;
    assign o_status           = r_out_status;
    assign o_last             = r_out_last;

    // Checks on the interlock between the ring ports and the divider, and on the source of a result.
    `FSA_ASSERT_IMP(a_no_rw_overlap, i_clk, i_rst_n, mem_we, !rd_en && !r_s1_valid, "ring clash")
    `FSA_ASSERT_IMP(a_div_done_state, i_clk, i_rst_n, div_res.done, r_state == ST_DIV, "stray done")
    `FSA_ASSERT_NXT(a_div_running, i_clk, i_rst_n, div_start, r_state == ST_DIV && !div_res.done, "no wait")
    `FSA_ASSERT_IMP(a_strobe_source, i_clk, i_rst_n, o_strobe, $past(busy) || $past(start), "stray result")

endmodule

>>> verif/fifo_slot_allocator_tb.sv
`timescale 1ns / 1ps

module fifo_slot_allocator_tb;
    import fsa_pkg::*;

    localparam int SLOTS         = 1024;
    localparam int MAX_RUN       = 64;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RAND_PHASES   = 5;
    localparam int PHASE_ITEMS   = 50;
    localparam int QUIET_ITEMS   = 40;

    // Codes that the block has no name for: an unused function and an unused register.
    localparam logic [FUNC_W-1:0]    FUNC_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 3'd7;

    typedef struct packed {
        logic [ADDR_W-1:0] cpu_addr;
        logic [ADDR_W-1:0] gpu_addr;
        logic [IDX_W-1:0]  index;
        logic [STAT_W-1:0] status;
        logic              last;
    } t_slot_result;

    typedef enum logic {ROW_REQ, ROW_REG} t_row_kind;

    // One row of the directed plan: a request, or a register write.
    typedef struct {
        t_row_kind            kind;
        logic [FUNC_W-1:0]    func;
        logic [RUN_W-1:0]     run;
        logic [ADDR_W-1:0]    value;
        logic [CFG_IDX_W-1:0] sel;
        logic                 check;
        logic [STAT_W-1:0]    status;
        logic [IDX_W-1:0]     index;
    } t_plan_row;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx       = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  start           = 1'b0;
    logic                  busy;
    logic [FUNC_W-1:0]     i_func          = '0;
    logic [RUN_W-1:0]      i_run_length    = '0;
    logic [ADDR_W-1:0]     i_freed_address = '0;
    logic                  o_strobe;
    logic [ADDR_W-1:0]     o_slot_cpu_address;
    logic [ADDR_W-1:0]     o_slot_gpu_address;
    logic [IDX_W-1:0]      o_slot_index;
    logic [STAT_W-1:0]     o_status;
    logic                  o_last;

    // Predictor copy of the registers and the free ring.
    logic [ADDR_W-1:0]  cpu_base_q;
    logic [ADDR_W-1:0]  gpu_base_q;
    logic [SIZE_W-1:0]  slot_size_q;
    logic [COUNT_W-1:0] slot_count_q;
    logic               gpu_visible_q;
    logic [IDX_W-1:0]   free_ring [SLOTS];
    logic [IDX_W-1:0]   ring_head;
    int unsigned        free_total;

    t_slot_result     expected_slots_q[$];
    t_slot_result     request_results[$];
    logic [IDX_W-1:0] held_slots_q[$];
    t_plan_row        plan[$];

    int err_cnt      = 0;
    int results_seen = 0;
    int cycle_count  = 0;
    int alloc_cnt    = 0;
    int free_cnt     = 0;
    int refill_cnt   = 0;
    int ignored_cnt  = 0;
    int reg_writes   = 0;

    fifo_slot_allocator #(
        .SLOTS   (SLOTS),
        .MAX_RUN (MAX_RUN)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .start              (start),
        .busy               (busy),
        .i_func             (i_func),
        .i_run_length       (i_run_length),
        .i_freed_address    (i_freed_address),
        .o_strobe           (o_strobe),
        .o_slot_cpu_address (o_slot_cpu_address),
        .o_slot_gpu_address (o_slot_gpu_address),
        .o_slot_index       (o_slot_index),
        .o_status           (o_status),
        .o_last             (o_last)
    );

    always #10 i_clk = ~i_clk;

    // Stop a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [ADDR_W-1:0] rand48();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    // Slot count as the ring sees it: clamped to the ring depth.
    function automatic int unsigned usable_slots();
        if (slot_count_q > SLOTS)
            return SLOTS;
        return slot_count_q;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_offset(logic [IDX_W-1:0] slot);
        return ADDR_W'(slot) * ADDR_W'(slot_size_q);
    endfunction

    function automatic t_plan_row req_row(logic [FUNC_W-1:0] func, logic [RUN_W-1:0] run,
                                          logic [ADDR_W-1:0] addr, logic check,
                                          logic [STAT_W-1:0] status, logic [IDX_W-1:0] index);
        return '{ROW_REQ, func, run, addr, CFG_CPU_BASE, check, status, index};
    endfunction

    function automatic t_plan_row reg_row(logic [CFG_IDX_W-1:0] sel, logic [ADDR_W-1:0] data);
        return '{ROW_REG, FUNC_ALLOC, '0, data, sel, 1'b0, STAT_OK, '0};
    endfunction

    // Append one row to the directed plan.
    function automatic void add_row(t_plan_row row);
        plan.insert(plan.size(), row);
    endfunction

    // Refill puts indices 0..n-1 back in order; slots handed out so far are forgotten.
    task automatic rebuild_free_ring();
        for (int i = 0; i < usable_slots(); i++)
            free_ring[i] = IDX_W'(i);
        ring_head  = '0;
        free_total = usable_slots();
        held_slots_q.delete();
    endtask

    task automatic apply_register(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] data);
        case (sel)
            CFG_CPU_BASE:    cpu_base_q    = data[ADDR_W-1:0];
            CFG_GPU_BASE:    gpu_base_q    = data[ADDR_W-1:0];
            CFG_SLOT_SIZE:   slot_size_q   = data[SIZE_W-1:0];
            CFG_SLOT_COUNT:  slot_count_q  = data[COUNT_W-1:0];
            CFG_GPU_VISIBLE: gpu_visible_q = data[0];
            default: ;
        endcase
    endtask

    // Work out the slot results of one accepted request and queue them.
    task automatic predict_slots(logic [FUNC_W-1:0] func, logic [RUN_W-1:0] run,
                                 logic [ADDR_W-1:0] addr);
        int unsigned       n;
        logic [ADDR_W-1:0] off;
        logic [ADDR_W-1:0] quo;
        logic [IDX_W-1:0]  slot;
        logic [IDX_W-1:0]  tail;
        t_slot_result      res;
        request_results.delete();
        case (func)
            FUNC_ALLOC: begin
                n = (run > MAX_RUN) ? MAX_RUN : run;
                if (n > free_total) begin
                    res        = '0;
                    res.status = STAT_NOT_ENOUGH;
                    res.last   = 1'b1;
                    request_results.insert(request_results.size(), res);
                end else begin
                    for (int k = 0; k < n; k++) begin
                        slot         = free_ring[ring_head];
                        off          = slot_offset(slot);
                        res.cpu_addr = cpu_base_q + off;
                        res.gpu_addr = gpu_visible_q ? gpu_base_q + off : '0;
                        res.index    = slot;
                        res.status   = STAT_OK;
                        res.last     = (k == n - 1);
                        request_results.insert(request_results.size(), res);
                        held_slots_q.insert(held_slots_q.size(), slot);
                        ring_head = ring_head + 1'b1;
                        free_total--;
                    end
                end
            end
            FUNC_FREE: begin
                res      = '0;
                res.last = 1'b1;
                if (addr < cpu_base_q) begin
                    res.status = STAT_RANGE;
                end else begin
                    off = addr - cpu_base_q;
                    if (slot_size_q == 0 || off % slot_size_q != 0) begin
                        res.status = STAT_MISALIGNED;
                    end else begin
                        quo = off / slot_size_q;
                        if (quo >= usable_slots()) begin
                            res.status = STAT_RANGE;
                        end else if (free_total >= SLOTS) begin
                            res.status = STAT_RING_FULL;
                            res.index  = quo[IDX_W-1:0];
                        end else begin
                            tail            = ring_head + IDX_W'(free_total);
                            free_ring[tail] = quo[IDX_W-1:0];
                            free_total++;
                            res.status = STAT_OK;
                            res.index  = quo[IDX_W-1:0];
                        end
                    end
                end
                request_results.insert(request_results.size(), res);
            end
            FUNC_REFILL: rebuild_free_ring();
            default: ;
        endcase
        foreach (request_results[i])
            expected_slots_q.insert(expected_slots_q.size(), request_results[i]);
    endtask

    // Hold start high until a transaction is taken, then predict it.
    task automatic send_request(logic [FUNC_W-1:0] func, logic [RUN_W-1:0] run,
                                logic [ADDR_W-1:0] addr);
        start           <= 1'b1;
        i_func          <= func;
        i_run_length    <= run;
        i_freed_address <= addr;
        do @(posedge i_clk); while (busy);
        predict_slots(func, run, addr);
        case (func)
            FUNC_ALLOC:  alloc_cnt++;
            FUNC_FREE:   free_cnt++;
            FUNC_REFILL: refill_cnt++;
            default:     ignored_cnt++;
        endcase
    endtask

    task automatic idle_for(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Wait for every expected result, then give a free or refill time to finish.
    task automatic settle();
        start <= 1'b0;
        while (expected_slots_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The write enable stays high; the caller lowers it after the last write.
    task automatic write_register(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= sel;
        i_cfg_data <= data;
        @(posedge i_clk);
        apply_register(sel, data);
        reg_writes++;
    endtask

    function automatic logic [RUN_W-1:0] random_run();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return RUN_W'($urandom_range(MAX_RUN + 1, 127));
            2, 3:    return RUN_W'($urandom_range(9, MAX_RUN));
            default: return RUN_W'($urandom_range(1, 8));
        endcase
    endfunction

    // Half of them frees of slots that were handed out, the rest bad or duplicate addresses.
    function automatic logic [ADDR_W-1:0] random_free_address();
        int               pos;
        logic [IDX_W-1:0] slot;
        slot = (usable_slots() == 0) ? '0 : IDX_W'($urandom_range(0, usable_slots() - 1));
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                if (held_slots_q.size() == 0)
                    return cpu_base_q + slot_offset(slot);
                pos  = $urandom_range(0, held_slots_q.size() - 1);
                slot = held_slots_q[pos];
                held_slots_q.delete(pos);
                return cpu_base_q + slot_offset(slot);
            end
            5:       return cpu_base_q + slot_offset(slot);
            6:       return cpu_base_q + slot_offset(slot) + ADDR_W'($urandom_range(1, 4095));
            7:       return cpu_base_q - ADDR_W'($urandom_range(1, 4096));
            8:       return cpu_base_q + ADDR_W'(usable_slots()) * ADDR_W'(slot_size_q)
                            + slot_offset(IDX_W'($urandom_range(0, 3)));
            default: return rand48();
        endcase
    endfunction

    task automatic random_request();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            send_request(FUNC_ALLOC, random_run(), rand48());
        else if (pick < 88)
            send_request(FUNC_FREE, RUN_W'($urandom), random_free_address());
        else if (pick < 94)
            send_request(FUNC_REFILL, RUN_W'($urandom), rand48());
        else
            send_request(FUNC_UNUSED, random_run(), rand48());
    endtask

    // New register setting for a random phase, followed by a refill.
    task automatic configure_random();
        logic [CFG_DATA_W-1:0] word;
        settle();
        case ($urandom_range(0, 3))
            0:       write_register(CFG_CPU_BASE, '0);
            1:       write_register(CFG_CPU_BASE, rand48());
            2:       write_register(CFG_CPU_BASE, {ADDR_W{1'b1}} - $urandom_range(0, 65535));
            default: write_register(CFG_CPU_BASE, CFG_DATA_W'($urandom_range(0, 65535)));
        endcase
        write_register(CFG_GPU_BASE, rand48());
        word = rand48();
        case ($urandom_range(0, 6))
            0:       word[SIZE_W-1:0] = SIZE_W'(1);
            1:       word[SIZE_W-1:0] = SIZE_W'(4096);
            2:       word[SIZE_W-1:0] = SIZE_W'(1 << $urandom_range(0, 12));
            3, 4:    word[SIZE_W-1:0] = SIZE_W'($urandom_range(1, 4096));
            5:       word[SIZE_W-1:0] = SIZE_W'($urandom_range(4097, 8191));
            default: word[SIZE_W-1:0] = '0;
        endcase
        write_register(CFG_SLOT_SIZE, word);
        word = rand48();
        case ($urandom_range(0, 5))
            0:       word[COUNT_W-1:0] = COUNT_W'(1);
            1:       word[COUNT_W-1:0] = COUNT_W'(SLOTS);
            2, 3:    word[COUNT_W-1:0] = COUNT_W'($urandom_range(2, 64));
            4:       word[COUNT_W-1:0] = COUNT_W'($urandom_range(1, 2047));
            default: word[COUNT_W-1:0] = '0;
        endcase
        write_register(CFG_SLOT_COUNT, word);
        write_register(CFG_GPU_VISIBLE, rand48());
        i_cfg_we <= 1'b0;
        send_request(FUNC_REFILL, RUN_W'($urandom), rand48());
    endtask

    // Compare every result against the oldest expectation.
    always @(posedge i_clk) begin
        t_slot_result want;
        if (i_rst_n && o_strobe) begin
            results_seen++;
            if (expected_slots_q.size() == 0) begin
                $error("unexpected result: slot_index %0d status %0d", o_slot_index, o_status);
                err_cnt++;
            end else begin
                want = expected_slots_q.pop_front();
                if (o_slot_cpu_address !== want.cpu_addr) begin
                    $error("slot_cpu_address: expected %h, got %h", want.cpu_addr,
                           o_slot_cpu_address);
                    err_cnt++;
                end
                if (o_slot_gpu_address !== want.gpu_addr) begin
                    $error("slot_gpu_address: expected %h, got %h", want.gpu_addr,
                           o_slot_gpu_address);
                    err_cnt++;
                end
                if (o_slot_index !== want.index) begin
                    $error("slot_index: expected %0d, got %0d", want.index, o_slot_index);
                    err_cnt++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    err_cnt++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        int reqs_left;

        // Predictor starts from the reset values.
        cpu_base_q    = '0;
        gpu_base_q    = '0;
        slot_size_q   = SIZE_W'(SLOT_SIZE_RST);
        slot_count_q  = COUNT_W'(SLOT_COUNT_RST);
        gpu_visible_q = 1'b0;
        rebuild_free_ring();

        // Reset defaults: 32-byte slots, 1024 of them, base zero.
        add_row(req_row(FUNC_ALLOC,  7'd1,   48'd0, 1'b1, STAT_OK, 10'd0));
        add_row(req_row(FUNC_ALLOC,  7'd64,  48'd0, 1'b1, STAT_OK, 10'd1));
        add_row(req_row(FUNC_ALLOC,  7'd127, 48'd0, 1'b1, STAT_OK, 10'd65));
        add_row(req_row(FUNC_ALLOC,  7'd0,   48'd0, 1'b0, STAT_OK, 10'd0));
        add_row(req_row(FUNC_FREE,   7'd0,   48'd0, 1'b1, STAT_OK, 10'd0));
        add_row(req_row(FUNC_FREE,   7'd0,   48'd33, 1'b1, STAT_MISALIGNED, 10'd0));
        add_row(req_row(FUNC_FREE,   7'd0,   48'd32768, 1'b1, STAT_RANGE, 10'd0));
        add_row(req_row(FUNC_FREE,   7'd0,   48'hFFFF_FFFF_FFE0, 1'b1, STAT_RANGE, 10'd0));
        add_row(req_row(FUNC_UNUSED, 7'd127, 48'hFFFF_FFFF_FFFF, 1'b0, STAT_OK, 10'd0));
        add_row(req_row(FUNC_REFILL, 7'd0,   48'd0, 1'b0, STAT_OK, 10'd0));
        add_row(req_row(FUNC_FREE,   7'd0,   48'd32, 1'b1, STAT_RING_FULL, 10'd1));
        // Three 4 KiB slots at the top of the address space, so slot addresses wrap.
        add_row(reg_row(CFG_CPU_BASE,    48'hFFFF_FFFF_F000));
        add_row(reg_row(CFG_GPU_BASE,    48'hFFFF_FFFF_FFFF));
        add_row(reg_row(CFG_SLOT_SIZE,   48'd4096));
        add_row(reg_row(CFG_SLOT_COUNT,  48'd3));
        add_row(reg_row(CFG_GPU_VISIBLE, 48'd1));
        add_row(reg_row(CFG_UNUSED,      48'hFFFF_FFFF_FFFF));
        add_row(req_row(FUNC_REFILL, 7'd0, 48'd0, 1'b0, STAT_OK, 10'd0));
        add_row(req_row(FUNC_ALLOC,  7'd4, 48'd0, 1'b1, STAT_NOT_ENOUGH, 10'd0));
        add_row(req_row(FUNC_ALLOC,  7'd3, 48'd0, 1'b1, STAT_OK, 10'd0));
        add_row(req_row(FUNC_FREE,   7'd0, 48'd0, 1'b1, STAT_RANGE, 10'd0));
        add_row(req_row(FUNC_FREE,   7'd0, 48'hFFFF_FFFF_F000, 1'b1, STAT_OK, 10'd0));
        add_row(req_row(FUNC_FREE,   7'd0, 48'hFFFF_FFFF_F800, 1'b1, STAT_MISALIGNED,
                        10'd0));
        add_row(req_row(FUNC_ALLOC,  7'd1, 48'd0, 1'b1, STAT_OK, 10'd0));
        // Zero slot size: every free is misaligned.
        add_row(reg_row(CFG_SLOT_SIZE,   48'd0));
        add_row(reg_row(CFG_CPU_BASE,    48'd0));
        add_row(reg_row(CFG_GPU_VISIBLE, 48'd0));
        add_row(req_row(FUNC_FREE,   7'd0, 48'd0, 1'b1, STAT_MISALIGNED, 10'd0));
        // Largest slot size and a slot count above the ring depth.
        add_row(reg_row(CFG_SLOT_SIZE,  48'd8191));
        add_row(reg_row(CFG_SLOT_COUNT, 48'd2047));
        add_row(req_row(FUNC_REFILL, 7'd0, 48'd0, 1'b0, STAT_OK, 10'd0));
        add_row(req_row(FUNC_ALLOC,  7'd2, 48'd0, 1'b1, STAT_OK, 10'd0));
        add_row(req_row(FUNC_FREE,   7'd0, 48'd8379393, 1'b1, STAT_OK, 10'd1023));
        add_row(req_row(FUNC_FREE,   7'd0, 48'd8387584, 1'b1, STAT_RANGE, 10'd0));
        // Zero slot count leaves the ring empty.
        add_row(reg_row(CFG_SLOT_COUNT, 48'd0));
        add_row(req_row(FUNC_REFILL, 7'd0, 48'd0, 1'b0, STAT_OK, 10'd0));
        add_row(req_row(FUNC_ALLOC,  7'd1, 48'd0, 1'b1, STAT_NOT_ENOUGH, 10'd0));
        add_row(req_row(FUNC_FREE,   7'd0, 48'd0, 1'b1, STAT_RANGE, 10'd0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed plan; rows with a known answer are also checked against the predictor.
        foreach (plan[r]) begin
            if (plan[r].kind == ROW_REG) begin
                if (r == 0 || plan[r-1].kind != ROW_REG)
                    settle();
                write_register(plan[r].sel, plan[r].value);
            end else begin
                if (r > 0 && plan[r-1].kind == ROW_REG)
                    i_cfg_we <= 1'b0;
                send_request(plan[r].func, plan[r].run, plan[r].value);
                if (plan[r].check && (request_results.size() == 0 ||
                    request_results[0].status != plan[r].status ||
                    request_results[0].index != plan[r].index)) begin
                    $error("directed row %0d: expected status %0d index %0d, predicted %0d %0d",
                           r, plan[r].status, plan[r].index,
                           request_results.size() ? request_results[0].status : '0,
                           request_results.size() ? request_results[0].index : '0);
                    err_cnt++;
                end
                if ($urandom_range(0, 3) == 0)
                    idle_for($urandom_range(1, 8));
            end
        end

        // Random phases, each under a fresh register setting; the tail runs without gaps.
        reqs_left = RAND_PHASES * PHASE_ITEMS;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            configure_random();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_request();
                reqs_left--;
                if (reqs_left > QUIET_ITEMS && $urandom_range(0, 3) == 0)
                    idle_for($urandom_range(1, 8));
            end
        end

        settle();
        $display("Covered %0d allocates, %0d frees, %0d refills and %0d unused codes.",
                 alloc_cnt, free_cnt, refill_cnt, ignored_cnt);
        $display("Checked %0d slot results over %0d register writes; %0d mismatches.",
                 results_seen, reg_writes, err_cnt);
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
